// ===== src/iirdf1_pkg.sv =====
package iirdf1_pkg;

   localparam int FF_MAX = 4;
   localparam int FB_MAX = 3;
   localparam int FF_TAPS_DEFAULT = 4;
   localparam int FB_TAPS_DEFAULT = 3;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W = 16;
   localparam int DATA_W = 32;
   localparam int PROD_W = COEF_W + DATA_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int AHEAD_W = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic     vld;
      data_type acc;
   } stage_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FF_COEF_0     = 3'd0,
      CSR_FF_COEF_1     = 3'd1,
      CSR_FF_COEF_2     = 3'd2,
      CSR_FF_COEF_3     = 3'd3,
      CSR_FB_COEF_0     = 3'd4,
      CSR_FB_COEF_1     = 3'd5,
      CSR_FB_COEF_2     = 3'd6,
      CSR_OUTPUT_OFFSET = 3'd7
   } csr_index_type;

endpackage

// ===== src/iirdf1_ff_cell.sv =====
module iirdf1_ff_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  iirdf1_pkg::sample_type sample_up,
   input  iirdf1_pkg::coef_type   coef,
   output iirdf1_pkg::sample_type sample_dn,
   output iirdf1_pkg::data_type   prod_out
);

   iirdf1_pkg::sample_type hold_ff, hold_in;
   iirdf1_pkg::data_type   prod_ff, prod_in;

   always_comb begin
      hold_in = hold_ff;
      prod_in = prod_ff;
      if (load) begin
         hold_in = sample_up;
         prod_in = iirdf1_pkg::data_type'(coef) * iirdf1_pkg::data_type'(sample_up);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign sample_dn = hold_ff;
   assign prod_out  = prod_ff;

endmodule

// ===== src/iirdf1_fb_cell.sv =====
module iirdf1_fb_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  iirdf1_pkg::stage_type stage_up,
   input  iirdf1_pkg::coef_type  coef,
   input  iirdf1_pkg::data_type  y_op,
   input  logic                  hist_shift,
   input  iirdf1_pkg::data_type  hist_up,
   output iirdf1_pkg::stage_type stage_dn,
   output iirdf1_pkg::data_type  hist_dn,
   output iirdf1_pkg::data_type  sum_out
);

   logic signed [iirdf1_pkg::PROD_W-1:0] prod_full;
   logic                 vld_ff, vld_in;
   iirdf1_pkg::data_type acc_ff, acc_in;
   iirdf1_pkg::data_type hist_ff, hist_in;

   always_comb begin
      prod_full = coef * y_op;
      sum_out   = stage_up.acc + prod_full[iirdf1_pkg::DATA_W-1:0];
      vld_in    = stage_up.vld;
      acc_in    = stage_up.vld ? sum_out : acc_ff;
      hist_in   = hist_shift ? hist_up : hist_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         hist_ff <= '0;
      end else begin
         vld_ff  <= vld_in;
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign stage_dn.vld = vld_ff;
   assign stage_dn.acc = acc_ff;
   assign hist_dn      = hist_ff;

endmodule

// ===== src/iir_direct_form_one_filter.sv =====
// direct-form-I iir filter, one filtered item per sample item
// req channel: req_sample is taken when req_valid and req_ready are both high
// rsp channel: rsp_filtered is offered while rsp_valid is high, taken with rsp_ready
// csr port: csr_wen writes csr_wdata into the register csr_index in the same edge;
//   registers 0..3 feedforward coefficients, 4..6 feedback coefficients, 7 offset
// throughput: one item per cycle while req_ready is high; the feedback
//   recurrence closes through one 16x32 multiply and add in each feedback
//   cell, the feedforward taps are parallel
// pipeline: feedforward cells form products, one adder stage sums them with the
//   offset, then a row of FB_TAPS feedback cells each adds one feedback term
// results land in a small output queue; req_ready drops once queued plus in-flight
//   items fill it, so a stalled receiver holds back new samples without losing any
// reset: clears coefficients, offset, sample and output history, queue and pipeline
module iir_direct_form_one_filter #(
   parameter int FF_TAPS = iirdf1_pkg::FF_TAPS_DEFAULT,
   parameter int FB_TAPS = iirdf1_pkg::FB_TAPS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  iirdf1_pkg::sample_type                 req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output iirdf1_pkg::data_type                   rsp_filtered,
   input  logic                                   csr_wen,
   input  logic [iirdf1_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [iirdf1_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NSTAGE    = FB_TAPS + 1;
   localparam int OUT_DEPTH = 2 ** $clog2(FB_TAPS + 4);
   localparam int PTR_W     = $clog2(OUT_DEPTH);
   localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

   iirdf1_pkg::coef_type ff_coef_ff [iirdf1_pkg::FF_MAX];
   iirdf1_pkg::coef_type ff_coef_in [iirdf1_pkg::FF_MAX];
   iirdf1_pkg::coef_type fb_coef_ff [iirdf1_pkg::FB_MAX];
   iirdf1_pkg::coef_type fb_coef_in [iirdf1_pkg::FB_MAX];
   iirdf1_pkg::data_type offset_ff, offset_in;

   logic                   req_fire;
   iirdf1_pkg::sample_type x_link  [FF_TAPS];
   iirdf1_pkg::data_type   ff_prod [FF_TAPS];
   iirdf1_pkg::data_type   ff_sum;
   logic                   a_vld_ff, a_vld_in;

   iirdf1_pkg::stage_type  stage [NSTAGE];
   iirdf1_pkg::stage_type  stage_b_ff, stage_b_in;

   iirdf1_pkg::data_type   out_mem [OUT_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       inflight;
   logic                   push, pop;

   // configuration registers
   always_comb begin
      ff_coef_in = ff_coef_ff;
      fb_coef_in = fb_coef_ff;
      offset_in  = offset_ff;
      if (csr_wen) begin
         case (iirdf1_pkg::csr_index_type'(csr_index))
            iirdf1_pkg::CSR_FF_COEF_0: begin
               ff_coef_in[0] = iirdf1_pkg::coef_type'(csr_wdata[iirdf1_pkg::COEF_W-1:0]);
            end
            iirdf1_pkg::CSR_FF_COEF_1: begin
               ff_coef_in[1] = iirdf1_pkg::coef_type'(csr_wdata[iirdf1_pkg::COEF_W-1:0]);
            end
            iirdf1_pkg::CSR_FF_COEF_2: begin
               ff_coef_in[2] = iirdf1_pkg::coef_type'(csr_wdata[iirdf1_pkg::COEF_W-1:0]);
            end
            iirdf1_pkg::CSR_FF_COEF_3: begin
               ff_coef_in[3] = iirdf1_pkg::coef_type'(csr_wdata[iirdf1_pkg::COEF_W-1:0]);
            end
            iirdf1_pkg::CSR_FB_COEF_0: begin
               fb_coef_in[0] = iirdf1_pkg::coef_type'(csr_wdata[iirdf1_pkg::COEF_W-1:0]);
            end
            iirdf1_pkg::CSR_FB_COEF_1: begin
               fb_coef_in[1] = iirdf1_pkg::coef_type'(csr_wdata[iirdf1_pkg::COEF_W-1:0]);
            end
            iirdf1_pkg::CSR_FB_COEF_2: begin
               fb_coef_in[2] = iirdf1_pkg::coef_type'(csr_wdata[iirdf1_pkg::COEF_W-1:0]);
            end
            iirdf1_pkg::CSR_OUTPUT_OFFSET: begin
               offset_in = iirdf1_pkg::data_type'(csr_wdata[iirdf1_pkg::DATA_W-1:0]);
            end
            default: begin
               offset_in = offset_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < iirdf1_pkg::FF_MAX; i++) begin
            ff_coef_ff[i] <= '0;
         end
         for (int i = 0; i < iirdf1_pkg::FB_MAX; i++) begin
            fb_coef_ff[i] <= '0;
         end
         offset_ff <= '0;
      end else begin
         ff_coef_ff <= ff_coef_in;
         fb_coef_ff <= fb_coef_in;
         offset_ff  <= offset_in;
      end
   end

   // feedforward cells
   assign req_fire  = req_valid & req_ready;
   assign x_link[0] = req_sample;

   for (genvar i = 0; i < FF_TAPS; i++) begin : g_ff
      if (i < FF_TAPS - 1) begin : g_mid
         iirdf1_ff_cell u_ff_cell (
            .clock     (clock),
            .reset     (reset),
            .load      (req_fire),
            .sample_up (x_link[i]),
            .coef      (ff_coef_ff[i]),
            .sample_dn (x_link[i+1]),
            .prod_out  (ff_prod[i])
         );
      end else begin : g_last
         iirdf1_ff_cell u_ff_cell (
            .clock     (clock),
            .reset     (reset),
            .load      (req_fire),
            .sample_up (x_link[i]),
            .coef      (ff_coef_ff[i]),
            .sample_dn (),
            .prod_out  (ff_prod[i])
         );
      end
   end

   // product sum plus offset
   always_comb begin
      ff_sum = offset_ff;
      for (int i = 0; i < FF_TAPS; i++) begin
         ff_sum = ff_sum + ff_prod[i];
      end
      a_vld_in       = req_fire;
      stage_b_in.vld = a_vld_ff;
      stage_b_in.acc = a_vld_ff ? ff_sum : stage_b_ff.acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff       <= 1'b0;
         stage_b_ff.vld <= 1'b0;
      end else begin
         a_vld_ff   <= a_vld_in;
         stage_b_ff <= stage_b_in;
      end
   end

   assign stage[FB_TAPS] = stage_b_ff;

   // feedback cells, the last one holds the newest output
   if (FB_TAPS > 0) begin : g_fb
      iirdf1_pkg::data_type hist_link [FB_TAPS];
      iirdf1_pkg::data_type hist_q    [FB_TAPS];
      iirdf1_pkg::data_type tail_sum;

      assign hist_link[0] = tail_sum;

      for (genvar j = 0; j < FB_TAPS; j++) begin : g_cell
         logic [iirdf1_pkg::AHEAD_W-1:0] ahead;
         iirdf1_pkg::data_type           y_op;

         if (j > 0) begin : g_link
            assign hist_link[j] = hist_q[j-1];
         end

         // items still in flight ahead of this one shift which history entry applies
         always_comb begin
            ahead = '0;
            for (int k = 1; k <= j; k++) begin
               ahead = ahead + iirdf1_pkg::AHEAD_W'(stage[k].vld);
            end
            y_op = hist_q[j];
            for (int k = 0; k <= j; k++) begin
               if (iirdf1_pkg::AHEAD_W'(j - k) == ahead) begin
                  y_op = hist_q[k];
               end
            end
         end

         if (j == 0) begin : g_tail
            iirdf1_fb_cell u_fb_cell (
               .clock      (clock),
               .reset      (reset),
               .stage_up   (stage[j+1]),
               .coef       (fb_coef_ff[j]),
               .y_op       (y_op),
               .hist_shift (stage[1].vld),
               .hist_up    (hist_link[j]),
               .stage_dn   (stage[j]),
               .hist_dn    (hist_q[j]),
               .sum_out    (tail_sum)
            );
         end else begin : g_body
            iirdf1_fb_cell u_fb_cell (
               .clock      (clock),
               .reset      (reset),
               .stage_up   (stage[j+1]),
               .coef       (fb_coef_ff[j]),
               .y_op       (y_op),
               .hist_shift (stage[1].vld),
               .hist_up    (hist_link[j]),
               .stage_dn   (stage[j]),
               .hist_dn    (hist_q[j]),
               .sum_out    ()
            );
         end
      end
   end

   // output queue
   assign push = stage[0].vld;
   assign pop  = rsp_valid & rsp_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
      inflight  = CNT_W'(a_vld_ff);
      for (int k = 0; k < NSTAGE; k++) begin
         inflight = inflight + CNT_W'(stage[k].vld);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_mem[wr_ptr_ff] <= stage[0].acc;
      end
   end

   assign rsp_valid    = (count_ff != '0);
   assign rsp_filtered = out_mem[rd_ptr_ff];
   assign req_ready    = ((count_ff + inflight) < CNT_W'(OUT_DEPTH));

endmodule

// ===== src/iirdf1_checker.sv =====
module iirdf1_checker #(
   parameter int FB_TAPS = iirdf1_pkg::FB_TAPS_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input iirdf1_pkg::data_type               rsp_filtered
);

   localparam int CAP   = 2 ** $clog2(FB_TAPS + 4);
   localparam int CNT_W = $clog2(CAP + 1);

   logic [CNT_W-1:0] pend_ff, pend_in;

   // items accepted but not yet delivered
   always_comb begin
      pend_in = pend_ff + CNT_W'(req_valid & req_ready) - CNT_W'(rsp_valid & rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("item offered with nothing pending");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= CNT_W'(CAP))
      else $error("more items pending than the queue can hold");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      pend_ff == CNT_W'(CAP) |-> !req_ready)
      else $error("req_ready high with the queue fully reserved");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered))
      else $error("stalled item changed or dropped");

endmodule

bind iir_direct_form_one_filter iirdf1_checker #(.FB_TAPS(FB_TAPS)) u_iirdf1_checker (.*);
